[sv/lfukv_pkg.sv]
// Shared types and constants for the LFU key-value cache.
package lfukv_pkg;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    localparam logic signed [31:0] READ_MISS = -32'sd1;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] COUNT_ONE = 32'd1;

    typedef struct packed {
        logic               func;
        logic signed [31:0] lookup_key;
        logic signed [31:0] write_value;
    } in_beat_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } out_beat_t;

    typedef struct packed {
        logic start;
        logic scan_rd;
        logic sweep_rd;
        logic decide;
        logic commit;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic need_update;
        logic out_free;
    } status_t;

endpackage

[sv/lfukv_ram.sv]
// Generic memory with one write port and one registered read port.
module lfukv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/lfukv_ctrl.sv]
// Controller state machine that sequences the scan, decision, rank sweep and commit.
module lfukv_ctrl #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              s_valid,
    output logic                                              s_ready,
    input  lfukv_pkg::status_t                                status,
    output lfukv_pkg::cmd_t                                   cmd,
    output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] addr
);

    import lfukv_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST = AW'(MAX_ENTRIES - 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_DRAIN  = 7'b0000100,
        ST_DECIDE = 7'b0001000,
        ST_SWEEP  = 7'b0010000,
        ST_COMMIT = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (cnt_reg == LAST) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = status.need_update ? ST_SWEEP : ST_DONE;
            end
            ST_SWEEP: begin
                cmd.sweep_rd = 1'b1;
                if (cnt_reg == LAST) begin
                    cnt_next   = '0;
                    state_next = ST_COMMIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign addr = cnt_reg;

endmodule

[sv/lfukv_dp.sv]
// Datapath holding the entry tables, search registers, decision logic and result register.
module lfukv_dp #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  lfukv_pkg::cmd_t                                   cmd,
    input  logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] addr,
    output lfukv_pkg::status_t                                status,
    input  lfukv_pkg::in_beat_t                               s_data,
    input  logic                                              cfg_valid,
    input  logic [lfukv_pkg::CAP_W-1:0]                       cfg_data,
    output logic                                              m_valid,
    input  logic                                              m_ready,
    output lfukv_pkg::out_beat_t                              m_data
);

    import lfukv_pkg::*;

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0]       capacity_reg;
    logic [MAX_ENTRIES-1:0] valid_reg;
    in_beat_t               in_reg;

    logic          eval_vld_reg, sw_vld_reg;
    logic [AW-1:0] eval_idx_reg, sw_idx_reg;

    logic          found_reg, free_reg, vic_reg;
    logic [AW-1:0] m_slot_reg, f_slot_reg, v_slot_reg;
    logic [31:0]   m_data_reg, m_count_reg, v_key_reg, v_count_reg;
    logic [AW-1:0] m_rank_reg, v_rank_reg;
    logic [CW-1:0] nvalid_reg;

    logic [AW-1:0] slot_reg, old_rank_reg;
    logic          inf_reg;
    logic [31:0]   nkey_reg, ndata_reg, ncount_reg;
    out_beat_t     res_reg, out_beat_reg;
    logic          m_valid_reg;

    logic [31:0]   key_rd, data_rd, count_rd;
    logic [AW-1:0] rank_rd;
    logic          e_valid;

    logic [CMP_W-1:0] cap_eff;
    logic             is_put;
    logic             upd;
    logic [AW-1:0]    t_slot, t_old_rank;
    logic             t_inf;
    logic [31:0]      t_key, t_data, t_count;
    out_beat_t        t_res;

    logic          rank_we;
    logic [AW-1:0] rank_wdata;

    lfukv_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_key_ram (
        .aclk  (aclk),
        .we    (cmd.commit),
        .waddr (slot_reg),
        .wdata (nkey_reg),
        .raddr (addr),
        .rdata (key_rd)
    );

    lfukv_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_data_ram (
        .aclk  (aclk),
        .we    (cmd.commit),
        .waddr (slot_reg),
        .wdata (ndata_reg),
        .raddr (addr),
        .rdata (data_rd)
    );

    lfukv_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_count_ram (
        .aclk  (aclk),
        .we    (cmd.commit),
        .waddr (slot_reg),
        .wdata (ncount_reg),
        .raddr (addr),
        .rdata (count_rd)
    );

    lfukv_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_rank_ram (
        .aclk  (aclk),
        .we    (rank_we),
        .waddr (sw_idx_reg),
        .wdata (rank_wdata),
        .raddr (addr),
        .rdata (rank_rd)
    );

    assign e_valid = valid_reg[eval_idx_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
            valid_reg    <= '0;
            eval_vld_reg <= 1'b0;
            sw_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                capacity_reg <= cfg_data;
            end
            if (cmd.commit) begin
                valid_reg[slot_reg] <= 1'b1;
            end
            eval_vld_reg <= cmd.scan_rd;
            sw_vld_reg   <= cmd.sweep_rd;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        eval_idx_reg <= addr;
        sw_idx_reg   <= addr;
        if (cmd.start) begin
            in_reg     <= s_data;
            found_reg  <= 1'b0;
            free_reg   <= 1'b0;
            vic_reg    <= 1'b0;
            nvalid_reg <= '0;
        end else if (eval_vld_reg) begin
            if (e_valid) begin
                nvalid_reg <= nvalid_reg + 1'b1;
                if (!found_reg && key_rd == in_reg.lookup_key) begin
                    found_reg   <= 1'b1;
                    m_slot_reg  <= eval_idx_reg;
                    m_data_reg  <= data_rd;
                    m_count_reg <= count_rd;
                    m_rank_reg  <= rank_rd;
                end
                if (!vic_reg || count_rd < v_count_reg ||
                    (count_rd == v_count_reg && rank_rd > v_rank_reg)) begin
                    vic_reg     <= 1'b1;
                    v_slot_reg  <= eval_idx_reg;
                    v_key_reg   <= key_rd;
                    v_count_reg <= count_rd;
                    v_rank_reg  <= rank_rd;
                end
            end else if (!free_reg) begin
                free_reg   <= 1'b1;
                f_slot_reg <= eval_idx_reg;
            end
        end
        if (cmd.decide) begin
            slot_reg     <= t_slot;
            old_rank_reg <= t_old_rank;
            inf_reg      <= t_inf;
            nkey_reg     <= t_key;
            ndata_reg    <= t_data;
            ncount_reg   <= t_count;
            res_reg      <= t_res;
        end
        if (cmd.load_out) begin
            out_beat_reg <= res_reg;
        end
    end

    always_comb begin
        if (CMP_W'(capacity_reg) > CMP_W'(MAX_ENTRIES)) begin
            cap_eff = CMP_W'(MAX_ENTRIES);
        end else begin
            cap_eff = CMP_W'(capacity_reg);
        end
        is_put            = (in_reg.func == FUNC_PUT);
        upd               = 1'b0;
        t_slot            = m_slot_reg;
        t_old_rank        = m_rank_reg;
        t_inf             = 1'b0;
        t_key             = in_reg.lookup_key;
        t_data            = in_reg.write_value;
        t_count           = COUNT_ONE;
        t_res.hit         = 1'b0;
        t_res.read_value  = is_put ? 32'sd0 : READ_MISS;
        t_res.evicted     = 1'b0;
        t_res.evicted_key = 32'sd0;
        if (cap_eff != '0) begin
            if (found_reg) begin
                upd              = 1'b1;
                t_res.hit        = 1'b1;
                t_res.read_value = is_put ? 32'sd0 : m_data_reg;
                t_data           = is_put ? in_reg.write_value : m_data_reg;
                t_count          = (m_count_reg == COUNT_MAX) ? m_count_reg
                                                              : m_count_reg + 32'd1;
            end else if (is_put) begin
                upd = 1'b1;
                if (CMP_W'(nvalid_reg) >= cap_eff || !free_reg) begin
                    t_res.evicted     = 1'b1;
                    t_res.evicted_key = v_key_reg;
                    t_slot            = v_slot_reg;
                    t_old_rank        = v_rank_reg;
                end else begin
                    t_slot     = f_slot_reg;
                    t_old_rank = '0;
                    t_inf      = 1'b1;
                end
            end
        end
    end

    always_comb begin
        rank_we    = 1'b0;
        rank_wdata = rank_rd + 1'b1;
        if (sw_vld_reg) begin
            if (sw_idx_reg == slot_reg) begin
                rank_we    = 1'b1;
                rank_wdata = '0;
            end else if (valid_reg[sw_idx_reg] && (inf_reg || rank_rd < old_rank_reg)) begin
                rank_we = 1'b1;
            end
        end
    end

    assign status.need_update = upd;
    assign status.out_free    = !m_valid_reg || m_ready;
    assign m_valid            = m_valid_reg;
    assign m_data             = out_beat_reg;

endmodule

[sv/lfu_key_value_cache.sv]
// Top level of the LFU key-value cache with least-recently-used tie-breaking.
// Each operation reads every one of the MAX_ENTRIES slots once, one slot per cycle, to find the
// key, a free slot and the replacement victim. An operation that changes the store then makes
// a second pass over the slots to age the recency ranks and writes the slot; a get miss, or
// any operation while the capacity register is zero, skips the second pass. The slots are read
// one at a time because the entry tables have one read port. A new input beat is taken while
// the previous result beat waits in the output register. The capacity register may be written
// at any time the block is idle, and takes effect on the next operation; its reset value is 16.
module lfu_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  lfukv_pkg::in_beat_t              s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output lfukv_pkg::out_beat_t             m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lfukv_pkg::CAP_W-1:0]      cfg_data
);

    import lfukv_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] addr;

    assign cfg_ready = 1'b1;

    lfukv_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd),
        .addr    (addr)
    );

    lfukv_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .addr      (addr),
        .status    (status),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
